@@ rtl/kmdb_pkg.sv @@
package kmdb_pkg;

	// Default sizes of the entry store.
	localparam int DEPTH_DEF         = 64;
	localparam int PAYLOAD_WIDTH_DEF = 64;

	// Fixed widths of the word fields.
	localparam int KEY_W   = 32;
	localparam int DATA_W  = 64;
	localparam int COUNT_W = 7;

	// Eviction amount after reset.
	localparam logic [COUNT_W-1:0] EVICT_RESET = 7'd20;

	// Operation codes of the func field.
	localparam logic FUNC_ENQUEUE = 1'b0;
	localparam logic FUNC_FIND    = 1'b1;

	// Input word.
	typedef struct packed {
		logic              func;
		logic [KEY_W-1:0]  request_key;
		logic [DATA_W-1:0] payload;
	} in_word_t;

	// Output word.
	typedef struct packed {
		logic               found;
		logic [DATA_W-1:0]  payload_out;
		logic [COUNT_W-1:0] dropped;
		logic [COUNT_W-1:0] occupancy;
	} out_word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic enq_do;
		logic search;
		logic shift;
		logic fin_do;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hit;
		logic search_end;
		logic shift_end;
	} ctrl_status_t;

endpackage

@@ rtl/keyed_match_dequeue_buffer_core.sv @@
// Keyed match-and-dequeue buffer with drop-oldest eviction.
// Input words arrive on in_valid/in_ready/in_data. An enqueue word appends
// its key and payload; when the buffer is full the oldest evict_amount
// entries (at least one, at most DEPTH) are dropped first. A find word
// searches from the oldest entry for the first matching key, returns its
// payload and removes it. Each input word yields exactly one output word on
// out_valid/out_ready/out_data, in order.
// An enqueue word's output is written from the ENQ state once the output
// register is free. A find scans one stored entry a cycle through the
// store's registered read port and then moves every later entry down by
// one place, one a cycle; its output is written from the FIN state once
// the output register is free. Only one word is handled at a time:
// in_ready is high only while idle, not while a word is in progress.
// The output register holds a finished word while the receiver stalls, and
// a new input word is still taken during that time; its result waits until
// the register frees up.
// The evict_amount register is written on cfg_valid/cfg_ready/cfg_data,
// which is always ready; it should be written only while the block is idle.
// Reset empties the buffer and sets evict_amount to 20. The store contents
// are not cleared, so the block is ready in the first cycle after reset.
module keyed_match_dequeue_buffer_core #(
	parameter int DEPTH         = kmdb_pkg::DEPTH_DEF,
	parameter int PAYLOAD_WIDTH = kmdb_pkg::PAYLOAD_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  kmdb_pkg::in_word_t           in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output kmdb_pkg::out_word_t          out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [kmdb_pkg::COUNT_W-1:0] cfg_data
);

	kmdb_pkg::ctrl_cmd_t    cmd;
	kmdb_pkg::ctrl_status_t status;

	// The register write port never stalls.
	assign cfg_ready = 1'b1;

	kmdb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_func   (in_data.func),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	kmdb_datapath #(
		.DEPTH         (DEPTH),
		.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_we   (cfg_valid),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);

endmodule

@@ rtl/kmdb_ctrl.sv @@
module kmdb_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_func,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  kmdb_pkg::ctrl_status_t status,
	output kmdb_pkg::ctrl_cmd_t   cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_ENQ    = 5'b00010,
		ST_SEARCH = 5'b00100,
		ST_SHIFT  = 5'b01000,
		ST_FIN    = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	// The output register can take a new word when empty or being drained.
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands.
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.accept = (state_q == ST_IDLE) && in_valid;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (in_func == kmdb_pkg::FUNC_FIND) ? ST_SEARCH : ST_ENQ;
				end
			end
			ST_ENQ: begin
				if (out_free) begin
					cmd.enq_do = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_SEARCH: begin
				cmd.search = 1'b1;
				if (status.hit) begin
					state_d = ST_SHIFT;
				end else if (status.search_end) begin
					state_d = ST_FIN;
				end
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				if (status.shift_end) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.fin_do = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.enq_do || cmd.fin_do) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/kmdb_datapath.sv @@
module kmdb_datapath #(
	parameter int DEPTH         = kmdb_pkg::DEPTH_DEF,
	parameter int PAYLOAD_WIDTH = kmdb_pkg::PAYLOAD_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  kmdb_pkg::in_word_t                    in_data,
	input  logic                                 cfg_we,
	input  logic [kmdb_pkg::COUNT_W-1:0]          cfg_data,
	input  kmdb_pkg::ctrl_cmd_t                   cmd,
	output kmdb_pkg::ctrl_status_t                status,
	output kmdb_pkg::out_word_t                   out_data
);

	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int EW   = (CW > kmdb_pkg::COUNT_W) ? CW : kmdb_pkg::COUNT_W;
	localparam logic [CW-1:0]   DEPTH_C = CW'(DEPTH);
	localparam logic [PTRW-1:0] LAST_P  = PTRW'(DEPTH - 1);
	localparam logic [EW-1:0]   DEPTH_E = EW'(DEPTH);

	// Entry store, kept as a ring from head to tail.
	logic [kmdb_pkg::KEY_W-1:0]  key_mem [DEPTH];
	logic [PAYLOAD_WIDTH-1:0]    pay_mem [DEPTH];

	logic [PTRW-1:0]             head_q, tail_q, rd_ptr_q, dst_q, addr_s1;
	logic [CW-1:0]               count_q, remain_q, idx_q, idx_s1;
	logic [kmdb_pkg::COUNT_W-1:0] evict_q;
	logic                        valid_s1, hit_q;
	logic [kmdb_pkg::KEY_W-1:0]  req_key_q;
	logic [PAYLOAD_WIDTH-1:0]    req_pay_q, hit_pay_q;
	logic [kmdb_pkg::KEY_W-1:0]  key_s1;
	logic [PAYLOAD_WIDTH-1:0]    pay_s1;
	kmdb_pkg::out_word_t          res_q;

	logic                        full, issue, hit, mem_we;
	logic [PTRW-1:0]             mem_waddr;
	logic [kmdb_pkg::KEY_W-1:0]  mem_wkey;
	logic [PAYLOAD_WIDTH-1:0]    mem_wpay;
	logic [EW-1:0]               evict_e, k_e;
	logic [CW-1:0]               k;
	logic [CW-1:0]               enq_count;

	// Step a ring pointer forward by one.
	function automatic logic [PTRW-1:0] ptr_inc(input logic [PTRW-1:0] p);
		ptr_inc = (p == LAST_P) ? '0 : p + 1'b1;
	endfunction

	// Step a ring pointer forward by up to DEPTH places.
	function automatic logic [PTRW-1:0] ptr_add(input logic [PTRW-1:0] p,
			input logic [CW-1:0] n);
		logic [CW:0] s;
		s = (CW+1)'(p) + (CW+1)'(n);
		if (s >= (CW+1)'(DEPTH)) begin
			s = s - (CW+1)'(DEPTH);
		end
		ptr_add = PTRW'(s);
	endfunction

	// Eviction amount, clamped to the range one to DEPTH.
	always_comb begin
		evict_e = EW'(evict_q);
		if (evict_q == '0) begin
			k_e = EW'(1);
		end else if (evict_e > DEPTH_E) begin
			k_e = DEPTH_E;
		end else begin
			k_e = evict_e;
		end
		k = CW'(k_e);
	end

	assign full      = (count_q == DEPTH_C);
	assign enq_count = full ? (DEPTH_C - k + 1'b1) : (count_q + 1'b1);
	assign issue     = (remain_q != '0);
	assign hit       = valid_s1 && (key_s1 == req_key_q);

	assign status.hit        = cmd.search && hit;
	assign status.search_end = !valid_s1 && !issue;
	assign status.shift_end  = !valid_s1 && !issue;
	assign out_data          = res_q;

	// Store write port: appends on enqueue, moves entries down on compaction.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = tail_q;
		mem_wkey  = req_key_q;
		mem_wpay  = req_pay_q;
		if (cmd.enq_do) begin
			mem_we = 1'b1;
		end else if (cmd.shift && valid_s1) begin
			mem_we    = 1'b1;
			mem_waddr = dst_q;
			mem_wkey  = key_s1;
			mem_wpay  = pay_s1;
		end
	end

	// Store with one write and one registered read a cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[mem_waddr] <= mem_wkey;
			pay_mem[mem_waddr] <= mem_wpay;
		end
		key_s1 <= key_mem[rd_ptr_q];
		pay_s1 <= pay_mem[rd_ptr_q];
	end

	// Captured request and matched payload.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_key_q <= in_data.request_key;
			req_pay_q <= in_data.payload[PAYLOAD_WIDTH-1:0];
		end
		if (cmd.search && hit) begin
			hit_pay_q <= pay_s1;
		end
	end

	// Result word.
	always_ff @(posedge clk) begin
		if (cmd.enq_do) begin
			res_q.found       <= 1'b0;
			res_q.payload_out <= '0;
			res_q.dropped     <= full ? kmdb_pkg::COUNT_W'(k) : '0;
			res_q.occupancy   <= kmdb_pkg::COUNT_W'(enq_count);
		end else if (cmd.fin_do) begin
			res_q.found       <= hit_q;
			res_q.payload_out <= hit_q ? kmdb_pkg::DATA_W'(hit_pay_q) : '0;
			res_q.dropped     <= '0;
			res_q.occupancy   <= hit_q ? kmdb_pkg::COUNT_W'(count_q - 1'b1)
				: kmdb_pkg::COUNT_W'(count_q);
		end
	end

	// Ring pointers, count, scan state and the eviction register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			rd_ptr_q <= '0;
			dst_q    <= '0;
			addr_s1  <= '0;
			remain_q <= '0;
			idx_q    <= '0;
			idx_s1   <= '0;
			valid_s1 <= 1'b0;
			hit_q    <= 1'b0;
			evict_q  <= kmdb_pkg::EVICT_RESET;
		end else begin
			if (cfg_we) begin
				evict_q <= cfg_data;
			end
			if (cmd.accept) begin
				rd_ptr_q <= head_q;
				remain_q <= count_q;
				idx_q    <= '0;
				valid_s1 <= 1'b0;
				hit_q    <= 1'b0;
			end
			// Append at the tail, dropping the oldest entries when full.
			if (cmd.enq_do) begin
				tail_q  <= ptr_inc(tail_q);
				count_q <= enq_count;
				if (full) begin
					head_q <= ptr_add(head_q, k);
				end
			end
			// Scan from the oldest entry, one compare a cycle.
			if (cmd.search) begin
				if (hit) begin
					hit_q    <= 1'b1;
					dst_q    <= addr_s1;
					rd_ptr_q <= ptr_inc(addr_s1);
					remain_q <= count_q - idx_s1 - 1'b1;
					valid_s1 <= 1'b0;
				end else begin
					valid_s1 <= issue;
					addr_s1  <= rd_ptr_q;
					idx_s1   <= idx_q;
					if (issue) begin
						rd_ptr_q <= ptr_inc(rd_ptr_q);
						remain_q <= remain_q - 1'b1;
						idx_q    <= idx_q + 1'b1;
					end
				end
			end
			// Close the gap: each later entry moves down by one place.
			if (cmd.shift) begin
				valid_s1 <= issue;
				if (issue) begin
					rd_ptr_q <= ptr_inc(rd_ptr_q);
					remain_q <= remain_q - 1'b1;
				end
				if (valid_s1) begin
					dst_q <= ptr_inc(dst_q);
				end
			end
			// After a removal the last moved slot becomes the new tail.
			if (cmd.fin_do && hit_q) begin
				tail_q  <= dst_q;
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
